// File: rtl/chs_pkg.sv
package chs_pkg;

  // Configuration register.
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Operation codes carried in the action field.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Field widths of the input and result words.
  localparam int KEY_W       = 24;
  localparam int PAY_W       = 16;
  localparam int PROBE_OUT_W = 3;
  localparam int CHAIN_OUT_W = 4;
  localparam int OCC_OUT_W   = 11;
  localparam int LONG_OUT_W  = 4;
  localparam int ENT_OUT_W   = 14;
  localparam int CNT_OUT_W   = 32;
  localparam int MAXP_OUT_W  = 3;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } chs_in_t;

  typedef struct packed {
    logic                   found;
    logic                   overflow;
    logic [PAY_W-1:0]       payload_out;
    logic [PROBE_OUT_W-1:0] probe_count;
    logic [CHAIN_OUT_W-1:0] chain_length;
    logic [OCC_OUT_W-1:0]   occupied_buckets;
    logic [LONG_OUT_W-1:0]  longest_chain;
    logic [ENT_OUT_W-1:0]   entries_total;
    logic [CNT_OUT_W-1:0]   found_total;
    logic [CNT_OUT_W-1:0]   probe_total;
    logic [MAXP_OUT_W-1:0]  max_probes;
  } chs_out_t;

endpackage

// File: rtl/chs_ram.sv
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/chs_mod_unit.sv
module chs_mod_unit #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 11,
  parameter int REM_W      = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [REM_W-1:0]      rem_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] dv_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVISOR_W:0]    trial;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, dv_q[DIVIDEND_W-1]};
    if (trial >= {1'b0, div_q}) begin
      trial = trial - {1'b0, div_q};
    end
    rem_d = trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dv_q  <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dv_q  <= dv_q << 1;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[REM_W-1:0];

endmodule

// File: rtl/chained_hash_table.sv
// An insert passes through the remainder unit, the fill read and the append before its
// result is loaded; a search also walks the chain, unless it is empty, until a hit or its
// end. One word is handled at a time: a new word is taken only after the previous result
// is loaded, a pace set by the bit-serial remainder unit (one key bit a cycle) and the
// one-entry-a-cycle chain walk. After reset the bucket fill memory is cleared, one bucket
// a cycle, and no word is taken until the clearing is done.
module chained_hash_table
  import chs_pkg::*;
#(
  parameter int BUCKETS      = 1024,
  parameter int CHAIN_DEPTH  = 8,
  parameter int KEY_BITS     = 24,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  chs_in_t          in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output chs_out_t         out_word_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int MOD_W   = $clog2(BUCKETS + 1);
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int FILL_W  = $clog2(CHAIN_DEPTH + 1);
  localparam int PROBE_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int SLOTS   = BUCKETS * CHAIN_DEPTH;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ENT_W   = $clog2(SLOTS + 1);
  localparam int ENTRY_W = KEY_BITS + PAYLOAD_BITS;

  // Sequencer state codes.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
  localparam logic [ST_W-1:0] ST_MOD   = 3'd2;
  localparam logic [ST_W-1:0] ST_FRD   = 3'd3;
  localparam logic [ST_W-1:0] ST_FWT   = 3'd4;
  localparam logic [ST_W-1:0] ST_WALK  = 3'd5;
  localparam logic [ST_W-1:0] ST_DONE  = 3'd6;

  // Clamp a count to the largest value of a result field that is w bits wide.
  function automatic logic [31:0] sat_w(input logic [31:0] v, input int w);
    logic [31:0] top;
    top = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    return (v > top) ? top : v;
  endfunction

  // Sequencer and captured word.
  logic [ST_W-1:0]         state_q, state_d;
  logic [BKT_W-1:0]        clr_q, clr_d;
  logic                    action_q, action_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [BKT_W-1:0]        bucket_q, bucket_d;
  logic [SLOT_W-1:0]       base_q, base_d;
  logic [PROBE_W-1:0]      ptr_q, ptr_d;

  // Result of the word in flight, before the statistics are attached.
  logic                    res_found_q, res_found_d;
  logic                    res_ovf_q, res_ovf_d;
  logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;
  logic [PROBE_W-1:0]      res_probe_q, res_probe_d;
  logic [FILL_W-1:0]       res_fill_q, res_fill_d;

  // Running statistics of the table.
  logic [MOD_W-1:0]        occ_q, occ_d;
  logic [FILL_W-1:0]       longest_q, longest_d;
  logic [ENT_W-1:0]        ent_q, ent_d;
  logic [31:0]             hit_q, hit_d;
  logic [31:0]             psum_q, psum_d;
  logic [PROBE_W-1:0]      pmax_q, pmax_d;
  logic [32:0]             psum_ext;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  chs_out_t                out_word_q, out_word_d;

  // Configuration register and the modulus derived from it.
  logic [CFG_W-1:0]        bucket_count_q;
  logic [MOD_W-1:0]        cfg_mod;

  // Remainder unit.
  logic                    mod_start;
  logic                    mod_done;
  logic [BKT_W-1:0]        mod_rem;

  // Memory ports.
  logic                    fill_we;
  logic [BKT_W-1:0]        fill_waddr;
  logic [FILL_W-1:0]       fill_wdata;
  logic [BKT_W-1:0]        fill_raddr;
  logic [FILL_W-1:0]       fill_rd;
  logic                    ent_we;
  logic [SLOT_W-1:0]       ent_waddr;
  logic [ENTRY_W-1:0]      ent_wdata;
  logic [SLOT_W-1:0]       ent_raddr;
  logic [ENTRY_W-1:0]      ent_rd;
  logic [FILL_W-1:0]       fill_inc;
  logic [FILL_W-1:0]       ptr_next;

  // A bucket count of zero acts as one, and one above the table size as the table size.
  always_comb begin
    if (bucket_count_q == '0) begin
      cfg_mod = MOD_W'(1);
    end else if (32'(bucket_count_q) > 32'(BUCKETS)) begin
      cfg_mod = MOD_W'(BUCKETS);
    end else begin
      cfg_mod = MOD_W'(bucket_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  // The bucket index is the key modulo the configured count, worked out one bit a cycle.
  chs_mod_unit #(
    .DIVIDEND_W (KEY_BITS),
    .DIVISOR_W  (MOD_W),
    .REM_W      (BKT_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (KEY_BITS'(in_word_i.key)),
    .divisor_i  (cfg_mod),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Chain length of each bucket.
  chs_ram #(
    .WIDTH (FILL_W),
    .DEPTH (BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rd)
  );

  // Key and payload of every slot; bucket b owns the CHAIN_DEPTH slots from b * CHAIN_DEPTH.
  chs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd)
  );

  assign fill_inc = fill_rd + FILL_W'(1);
  assign ptr_next = FILL_W'(ptr_q) + FILL_W'(1);
  assign psum_ext = {1'b0, psum_q} + 33'(ptr_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    action_d    = action_q;
    key_d       = key_q;
    pay_d       = pay_q;
    bucket_d    = bucket_q;
    base_d      = base_q;
    ptr_d       = ptr_q;
    res_found_d = res_found_q;
    res_ovf_d   = res_ovf_q;
    res_pay_d   = res_pay_q;
    res_probe_d = res_probe_q;
    res_fill_d  = res_fill_q;
    occ_d       = occ_q;
    longest_d   = longest_q;
    ent_d       = ent_q;
    hit_d       = hit_q;
    psum_d      = psum_q;
    pmax_d      = pmax_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    mod_start   = 1'b0;
    fill_we     = 1'b0;
    fill_waddr  = bucket_q;
    fill_wdata  = fill_inc;
    fill_raddr  = bucket_q;
    ent_we      = 1'b0;
    ent_waddr   = base_q + SLOT_W'(fill_rd);
    ent_wdata   = {key_q, pay_q};
    ent_raddr   = base_q;

    // The waiting result leaves as soon as the far side takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        // Zero the chain length of one bucket a cycle.
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        fill_wdata = '0;
        clr_d      = clr_q + BKT_W'(1);
        if (clr_q == BKT_W'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          action_d  = in_word_i.action;
          key_d     = KEY_BITS'(in_word_i.key);
          pay_d     = PAYLOAD_BITS'(in_word_i.payload);
          mod_start = 1'b1;
          state_d   = ST_MOD;
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          bucket_d = mod_rem;
          base_d   = SLOT_W'(32'(mod_rem) * CHAIN_DEPTH);
          state_d  = ST_FRD;
        end
      end

      ST_FRD: begin
        // The fill read at the bucket address is under way.
        state_d = ST_FWT;
      end

      ST_FWT: begin
        res_found_d = 1'b0;
        res_ovf_d   = 1'b0;
        res_pay_d   = '0;
        res_probe_d = '0;
        res_fill_d  = fill_rd;
        if (action_q == ACT_INSERT) begin
          if (32'(fill_rd) < 32'(CHAIN_DEPTH)) begin
            // Append at the end of the chain.
            ent_we      = 1'b1;
            fill_we     = 1'b1;
            res_fill_d  = fill_inc;
            res_found_d = 1'b1;
            ent_d       = ent_q + ENT_W'(1);
            if (fill_rd == '0) begin
              occ_d = occ_q + MOD_W'(1);
            end
            if (fill_inc > longest_q) begin
              longest_d = fill_inc;
            end
          end else begin
            res_ovf_d = 1'b1;
          end
          state_d = ST_DONE;
        end else if (fill_rd == '0) begin
          state_d = ST_DONE;
        end else begin
          // Fetch the head of the chain.
          ent_raddr = base_q;
          ptr_d     = '0;
          state_d   = ST_WALK;
        end
      end

      ST_WALK: begin
        // The entry at position ptr_q is on the read port; the next one is fetched
        // in the same cycle in case this one does not match.
        ent_raddr = base_q + SLOT_W'(ptr_next);
        if (ent_rd[ENTRY_W-1:PAYLOAD_BITS] == key_q) begin
          res_found_d = 1'b1;
          res_pay_d   = ent_rd[PAYLOAD_BITS-1:0];
          res_probe_d = ptr_q;
          if (hit_q != 32'hFFFF_FFFF) begin
            hit_d = hit_q + 32'd1;
          end
          psum_d = psum_ext[32] ? 32'hFFFF_FFFF : psum_ext[31:0];
          if (ptr_q > pmax_q) begin
            pmax_d = ptr_q;
          end
          state_d = ST_DONE;
        end else if (ptr_next < res_fill_q) begin
          ptr_d = ptr_q + PROBE_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Load the output register once the previous result has gone.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                 = 1'b1;
          out_word_d.found            = res_found_q;
          out_word_d.overflow         = res_ovf_q;
          out_word_d.payload_out      = PAY_W'(res_pay_q);
          out_word_d.probe_count      = PROBE_OUT_W'(sat_w(32'(res_probe_q), PROBE_OUT_W));
          out_word_d.chain_length     = CHAIN_OUT_W'(sat_w(32'(res_fill_q), CHAIN_OUT_W));
          out_word_d.occupied_buckets = OCC_OUT_W'(sat_w(32'(occ_q), OCC_OUT_W));
          out_word_d.longest_chain    = LONG_OUT_W'(sat_w(32'(longest_q), LONG_OUT_W));
          out_word_d.entries_total    = ENT_OUT_W'(sat_w(32'(ent_q), ENT_OUT_W));
          out_word_d.found_total      = hit_q;
          out_word_d.probe_total      = psum_q;
          out_word_d.max_probes       = MAXP_OUT_W'(sat_w(32'(pmax_q), MAXP_OUT_W));
          state_d                     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      occ_q       <= '0;
      longest_q   <= '0;
      ent_q       <= '0;
      hit_q       <= '0;
      psum_q      <= '0;
      pmax_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      occ_q       <= occ_d;
      longest_q   <= longest_d;
      ent_q       <= ent_d;
      hit_q       <= hit_d;
      psum_q      <= psum_d;
      pmax_q      <= pmax_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q    <= action_d;
    key_q       <= key_d;
    pay_q       <= pay_d;
    bucket_q    <= bucket_d;
    base_q      <= base_d;
    ptr_q       <= ptr_d;
    res_found_q <= res_found_d;
    res_ovf_q   <= res_ovf_d;
    res_pay_q   <= res_pay_d;
    res_probe_q <= res_probe_d;
    res_fill_q  <= res_fill_d;
    out_word_q  <= out_word_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // An insert is either stored or refused, never both.
  a_found_ovf_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.found && out_word_o.overflow))
    else $error("result flags both stored and refused");

  // A non-zero chain position is only reported for a hit.
  a_probe_needs_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.probe_count != '0)) |-> out_word_o.found)
    else $error("probe position reported without a hit");

  // Every chain was built by inserts, so none exceeds the longest chain seen.
  a_chain_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.chain_length <= out_word_o.longest_chain))
    else $error("chain length above longest chain");

  // The remainder unit only finishes while the sequencer is waiting for it.
  a_mod_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == ST_MOD))
    else $error("remainder finished outside its wait state");

  // The walk never looks beyond the end of the chain.
  a_walk_in_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (32'(ptr_q) < 32'(res_fill_q)))
    else $error("chain walk past the fill");

endmodule
